/* hw/rtl/uartrb_pkg.sv */
`timescale 1ns / 1ps

package uartrb_pkg;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int RX_PTR_W = $clog2(RX_DEPTH);
  localparam int TX_PTR_W = $clog2(TX_DEPTH);
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 6;
  localparam int REQ_W    = 2;
  localparam int CNT_MAX  = (1 << CNT_W) - 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_RX_BYTE  = 2'd0,
    REQ_TX_WRITE = 2'd1,
    REQ_SW_READ  = 2'd2,
    REQ_TX_READY = 2'd3
  } req_type_e;

  typedef logic [RX_PTR_W-1:0] rx_ptr_t;
  typedef logic [TX_PTR_W-1:0] tx_ptr_t;

  typedef struct packed {
    logic              we;
    rx_ptr_t           waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    rx_ptr_t           raddr;
  } rx_mem_req_t;

  typedef struct packed {
    logic              we;
    tx_ptr_t           waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    tx_ptr_t           raddr;
  } tx_mem_req_t;

  function automatic rx_ptr_t rx_next(input rx_ptr_t p);
    return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic tx_ptr_t tx_next(input tx_ptr_t p);
    return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] rx_fill(input rx_ptr_t wp, input rx_ptr_t rp);
    logic [RX_PTR_W:0] c;
    if (wp >= rp) begin
      c = {1'b0, wp} - {1'b0, rp};
    end else begin
      c = (RX_PTR_W + 1)'(RX_DEPTH) + {1'b0, wp} - {1'b0, rp};
    end
    if (int'(c) > CNT_MAX) begin
      return CNT_W'(CNT_MAX);
    end
    return CNT_W'(c);
  endfunction

  function automatic logic [CNT_W-1:0] tx_fill(input tx_ptr_t wp, input tx_ptr_t rp);
    logic [TX_PTR_W:0] c;
    if (wp >= rp) begin
      c = {1'b0, wp} - {1'b0, rp};
    end else begin
      c = (TX_PTR_W + 1)'(TX_DEPTH) + {1'b0, wp} - {1'b0, rp};
    end
    if (int'(c) > CNT_MAX) begin
      return CNT_W'(CNT_MAX);
    end
    return CNT_W'(c);
  endfunction

endpackage

/* hw/rtl/uartrb_req_if.sv */
`timescale 1ns / 1ps

interface uartrb_req_if import uartrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] byte_in;
  logic              line_idle;

  modport source (output valid, req_type, byte_in, line_idle, input ready);
  modport sink   (input valid, req_type, byte_in, line_idle, output ready);
endinterface

/* hw/rtl/uartrb_rsp_if.sv */
`timescale 1ns / 1ps

interface uartrb_rsp_if import uartrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              line_valid;
  logic [BYTE_W-1:0] line_byte;
  logic              read_valid;
  logic [BYTE_W-1:0] read_byte;
  logic              rx_dropped;
  logic              tx_rejected;
  logic [CNT_W-1:0]  rx_count;
  logic [CNT_W-1:0]  tx_count;

  modport source (output valid, line_valid, line_byte, read_valid, read_byte,
                  rx_dropped, tx_rejected, rx_count, tx_count, input ready);
  modport sink   (input valid, line_valid, line_byte, read_valid, read_byte,
                  rx_dropped, tx_rejected, rx_count, tx_count, output ready);
endinterface

/* hw/rtl/uart_rx_tx_ring_buffers_top.sv */
`timescale 1ns / 1ps
// Every response is registered in an output register; a request that pops a byte from a ring
// first passes through a read state, because the ring memories have a registered read port.
// One request per cycle is taken while no response stalls; a pop holds off the next request
// in its read state. A pending response is held in the output register until it is taken.
// Reset clears the ring pointers, the drain flag and the response valid; ring contents
// are not cleared and need no clearing pass.

module uart_rx_tx_ring_buffers_top import uartrb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  uartrb_req_if.sink   req_i,
  uartrb_rsp_if.source rsp_o
);

  rx_mem_req_t       rx_mem;
  tx_mem_req_t       tx_mem;
  logic [BYTE_W-1:0] rx_rdata;
  logic [BYTE_W-1:0] tx_rdata;

  uartrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .rx_mem_o   (rx_mem),
    .tx_mem_o   (tx_mem),
    .rx_rdata_i (rx_rdata),
    .tx_rdata_i (tx_rdata)
  );

  uartrb_ram #(
    .Width (BYTE_W),
    .Depth (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_mem.we),
    .waddr_i (rx_mem.waddr),
    .wdata_i (rx_mem.wdata),
    .re_i    (rx_mem.re),
    .raddr_i (rx_mem.raddr),
    .rdata_o (rx_rdata)
  );

  uartrb_ram #(
    .Width (BYTE_W),
    .Depth (TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_mem.we),
    .waddr_i (tx_mem.waddr),
    .wdata_i (tx_mem.wdata),
    .re_i    (tx_mem.re),
    .raddr_i (tx_mem.raddr),
    .rdata_o (tx_rdata)
  );

endmodule

/* hw/rtl/uartrb_ram.sv */
`timescale 1ns / 1ps

module uartrb_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/uartrb_ctrl.sv */
`timescale 1ns / 1ps

module uartrb_ctrl import uartrb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  uartrb_req_if.sink        req_i,
  uartrb_rsp_if.source      rsp_o,
  output rx_mem_req_t       rx_mem_o,
  output tx_mem_req_t       tx_mem_o,
  input  logic [BYTE_W-1:0] rx_rdata_i,
  input  logic [BYTE_W-1:0] tx_rdata_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_RX   = 2'd1;
  localparam logic [1:0] SRC_TX   = 2'd2;

  logic    state_q, state_d;
  rx_ptr_t rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d;
  tx_ptr_t tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d;
  logic    drain_q, drain_d;
  logic    out_valid_q;
  logic [1:0] src_q, src_d;

  logic              line_valid_q, read_valid_q, rx_dropped_q, tx_rejected_q;
  logic [BYTE_W-1:0] line_byte_q, read_byte_q;
  logic [CNT_W-1:0]  rx_count_q, tx_count_q;

  logic              lv, rv, drop, rej, direct;
  logic              accept;
  rx_ptr_t           rx_wp_inc, rx_rp_inc;
  tx_ptr_t           tx_wp_inc, tx_rp_inc;
  req_type_e         kind;

  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign kind        = req_type_e'(req_i.req_type);

  assign rx_wp_inc = rx_next(rx_wp_q);
  assign rx_rp_inc = rx_next(rx_rp_q);
  assign tx_wp_inc = tx_next(tx_wp_q);
  assign tx_rp_inc = tx_next(tx_rp_q);

  always_comb begin
    rx_wp_d  = rx_wp_q;
    rx_rp_d  = rx_rp_q;
    tx_wp_d  = tx_wp_q;
    tx_rp_d  = tx_rp_q;
    drain_d  = drain_q;
    src_d    = SRC_NONE;
    lv       = 1'b0;
    rv       = 1'b0;
    drop     = 1'b0;
    rej      = 1'b0;
    direct   = 1'b0;
    rx_mem_o = '{we: 1'b0, waddr: rx_wp_q, wdata: req_i.byte_in, re: 1'b0, raddr: rx_rp_q};
    tx_mem_o = '{we: 1'b0, waddr: tx_wp_q, wdata: req_i.byte_in, re: 1'b0, raddr: tx_rp_q};
    if (accept) begin
      case (kind)
        REQ_RX_BYTE: begin
          rx_mem_o.we = 1'b1;
          rx_wp_d     = rx_wp_inc;
          if (rx_wp_inc == rx_rp_q) begin
            rx_rp_d = rx_rp_inc;
            drop    = 1'b1;
          end
        end
        REQ_TX_WRITE: begin
          if ((tx_wp_q == tx_rp_q) && req_i.line_idle) begin
            lv     = 1'b1;
            direct = 1'b1;
          end else if (tx_wp_inc == tx_rp_q) begin
            rej = 1'b1;
          end else begin
            tx_mem_o.we = 1'b1;
            tx_wp_d     = tx_wp_inc;
            drain_d     = 1'b1;
          end
        end
        REQ_SW_READ: begin
          if (rx_wp_q != rx_rp_q) begin
            rx_mem_o.re = 1'b1;
            rx_rp_d     = rx_rp_inc;
            rv          = 1'b1;
            src_d       = SRC_RX;
          end
        end
        REQ_TX_READY: begin
          if (drain_q && (tx_wp_q != tx_rp_q)) begin
            tx_mem_o.re = 1'b1;
            tx_rp_d     = tx_rp_inc;
            lv          = 1'b1;
            src_d       = SRC_TX;
          end
          if (tx_wp_q == tx_rp_d) begin
            drain_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    if (accept && (src_d != SRC_NONE)) begin
      state_d = ST_READ;
    end else if (state_q == ST_READ) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rx_wp_q     <= '0;
      rx_rp_q     <= '0;
      tx_wp_q     <= '0;
      tx_rp_q     <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
      src_q       <= SRC_NONE;
    end else begin
      state_q <= state_d;
      rx_wp_q <= rx_wp_d;
      rx_rp_q <= rx_rp_d;
      tx_wp_q <= tx_wp_d;
      tx_rp_q <= tx_rp_d;
      drain_q <= drain_d;
      if (accept) begin
        out_valid_q <= (src_d == SRC_NONE);
        src_q       <= src_d;
      end else if (state_q == ST_READ) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_valid_q  <= lv;
      line_byte_q   <= direct ? req_i.byte_in : '0;
      read_valid_q  <= rv;
      read_byte_q   <= '0;
      rx_dropped_q  <= drop;
      tx_rejected_q <= rej;
      rx_count_q    <= rx_fill(rx_wp_d, rx_rp_d);
      tx_count_q    <= tx_fill(tx_wp_d, tx_rp_d);
    end else if (state_q == ST_READ) begin
      if (src_q == SRC_RX) begin
        read_byte_q <= rx_rdata_i;
      end
      if (src_q == SRC_TX) begin
        line_byte_q <= tx_rdata_i;
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.line_valid  = line_valid_q;
  assign rsp_o.line_byte   = line_byte_q;
  assign rsp_o.read_valid  = read_valid_q;
  assign rsp_o.read_byte   = read_byte_q;
  assign rsp_o.rx_dropped  = rx_dropped_q;
  assign rsp_o.tx_rejected = tx_rejected_q;
  assign rsp_o.rx_count    = rx_count_q;
  assign rsp_o.tx_count    = tx_count_q;

endmodule
